// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// File: hw/rtl/cvd_pkg.sv
package cvd_pkg;
	localparam int VecDepth = 256;
	localparam int IdxW = 8;
	localparam int LenW = 9;
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DIV = 1'b1;
	localparam logic [1:0] REG_CHAN_COUNT = 2'd0;
	localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
	localparam int QW = 27;

	typedef struct packed {
		logic        special;
		logic [31:0] special_val;
		logic        sign;
		logic signed [10:0] e;
		logic [23:0] ma;
		logic [23:0] mb;
	} div_op_t;

	function automatic logic [4:0] lzc24(input logic [23:0] m);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (m[i]) n = 5'(23 - i);
		end
		return n;
	endfunction
endpackage

// File: hw/rtl/cvd_divider.sv
// Radix-2 restoring divider for binary32, one quotient bit per cycle
module cvd_divider import cvd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  div_op_t     op,
	output logic        done,
	output logic [31:0] result
);
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [24:0] rem_q;
	logic [23:0] mb_q;
	logic [QW-1:0] quo_q;
	logic        sign_q;
	logic signed [10:0] e_q;
	logic        special_q;
	logic [31:0] spec_val_q;
	logic        fin_q;

	logic [25:0] trial;
	logic [24:0] rem_sh;
	always_comb begin
		rem_sh = {rem_q[23:0], 1'b0};
		trial = {1'b0, rem_sh} - {2'b0, mb_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= !op.special;
				fin_q <= op.special;
				cnt_q <= 5'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			special_q <= op.special;
			spec_val_q <= op.special_val;
			sign_q <= op.sign;
			mb_q <= op.mb;
			quo_q <= '0;
			// normalize so quotient lands in [1,2)
			if (op.ma < op.mb) begin
				rem_q <= {op.ma, 1'b0};
				e_q <= op.e - 11'sd1;
			end else begin
				rem_q <= {1'b0, op.ma};
				e_q <= op.e;
			end
		end else if (busy_q) begin
			// first cycle compares the unshifted remainder
			if (cnt_q == 5'(QW)) begin
				if (rem_q >= {1'b0, mb_q}) begin
					rem_q <= rem_q - {1'b0, mb_q};
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
			end else if (!trial[25]) begin
				rem_q <= trial[24:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	// round and pack
	logic [QW-1:0] q;
	logic signed [10:0] e;
	logic [10:0] sh;
	logic [QW-1:0] lostmask;
	logic [24:0] mant;
	logic [2:0] rb;
	logic [31:0] res;
	always_comb begin
		q = {quo_q[QW-1:1], quo_q[0] | (rem_q != '0)};
		e = e_q;
		sh = '0;
		lostmask = '0;
		if (e_q <= 11'sd0) begin
			sh = 11'(11'sd1 - e_q);
			if (sh >= 11'd32) begin
				q = {{(QW-1){1'b0}}, q != '0};
			end else begin
				lostmask = QW'((33'd1 << sh[4:0]) - 33'd1);
				q = (q >> sh[4:0]) | {{(QW-1){1'b0}}, (q & lostmask) != '0};
			end
			e = 11'sd1;
		end
		mant = {1'b0, q[QW-1:3]};
		rb = q[2:0];
		// a carry out of the mantissa bumps the exponent
		if (rb > 3'd4 || (rb == 3'd4 && mant[0])) mant = mant + 25'd1;
		res = {1'b0, e[7:0] - 8'd1, 23'd0} + {7'd0, mant};
		if (e_q >= 11'sd255 || res >= 32'h7F80_0000) res = 32'h7F80_0000;
		result = special_q ? spec_val_q : {sign_q, res[30:0]};
	end
	assign done = fin_q;

	`include "assert_macros.svh"
	`ASSERT_NEVER(a_start_busy, start && busy_q, "divider started while busy")
	`ASSERT_CLK(a_done_once, fin_q |=> !fin_q, "divider done held two cycles")
	`ASSERT_CLK(a_busy_cnt, busy_q |-> cnt_q != 5'd0, "busy with empty count")
endmodule

// File: hw/rtl/channelwise_vector_over_map_divide_unit.sv
// Channel  | Handshake          | Payload
// in       | in_valid/in_ready  | cmd, vec_index, value, last
// out      | out_valid/out_ready| quotient, channel, last_out
// cfg      | APB psel/penable   | channel count at byte 0
// A load transaction is taken whenever the unit is idle; loads can follow back to back.
// A divide reads the store at acceptance, decodes the operands in the read state,
// runs the divider and writes the output register; when an operand is zero, infinite
// or NaN the divider skips its iterations. The next transaction is taken the cycle
// after that write. If the output register is still full, the divider result waits
// and input stays blocked until the register frees. Reset zeroes the position, sets
// the length to 1 and leaves the vector store as is.
module channelwise_vector_over_map_divide_unit import cvd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  vec_index,
	input  logic [31:0] value,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] quotient,
	output logic [7:0]  channel,
	output logic        last_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;

	logic [1:0] state_q;
	logic [LenW-1:0] len_q;
	logic [IdxW-1:0] pos_q;
	logic [31:0] mem [VecDepth];
	logic [31:0] b_q;
	logic [IdxW-1:0] ch_q;
	logic last_q;
	logic out_valid_q;
	logic [31:0] quo_q;
	logic [IdxW-1:0] ch_out_q;
	logic last_out_q;

	logic in_acc, out_acc, div_done, wr_out;
	logic [31:0] div_res;
	div_op_t op;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_CHAN_COUNT) ? {23'd0, len_q} : 32'd0;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid_q && out_ready;
	// move the divider result out once the output register is free
	assign wr_out = ((state_q == ST_DIV && div_done) || state_q == ST_WAIT)
		&& (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (in_acc && cmd == CMD_LOAD) mem[vec_index] <= value;
	end

	logic [IdxW:0] nxt;
	assign nxt = {1'b0, pos_q} + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q <= 9'd1;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == REG_CHAN_COUNT)
				len_q <= pwdata[LenW-1:0];
			if (wr_out) out_valid_q <= 1'b1;
			else if (out_acc) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && cmd == CMD_DIV) begin
						state_q <= ST_READ;
						// advance the channel position, wrapping to zero on last or at the length
						if (last || nxt >= len_q || nxt[IdxW]) pos_q <= '0;
						else pos_q <= nxt[IdxW-1:0];
					end
				end
				ST_READ: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) state_q <= wr_out ? ST_IDLE : ST_WAIT;
				end
				ST_WAIT: begin
					if (wr_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && cmd == CMD_DIV) begin
			b_q <= value;
			ch_q <= pos_q;
			last_q <= last;
		end
		if (wr_out) begin
			quo_q <= div_res;
			ch_out_q <= ch_q;
			last_out_q <= last_q;
		end
	end

	// read the dividend at the position in use at acceptance
	logic [31:0] a_s1;
	always_ff @(posedge clk) begin
		if (in_acc && cmd == CMD_DIV) a_s1 <= mem[pos_q];
	end

	// operand decode
	logic [7:0] ea, eb;
	logic [22:0] fa, fb;
	logic [23:0] na, nb;
	logic [4:0] za, zb;
	logic signed [10:0] xa, xb;
	always_comb begin
		ea = a_s1[30:23]; fa = a_s1[22:0];
		eb = b_q[30:23];  fb = b_q[22:0];
		za = lzc24({1'b0, fa});
		zb = lzc24({1'b0, fb});
		if (ea == 8'd0) begin
			na = {1'b0, fa} << za;
			xa = 11'sd1 - 11'($unsigned(za));
		end else begin
			na = {1'b1, fa};
			xa = 11'($unsigned(ea));
		end
		if (eb == 8'd0) begin
			nb = {1'b0, fb} << zb;
			xb = 11'sd1 - 11'($unsigned(zb));
		end else begin
			nb = {1'b1, fb};
			xb = 11'($unsigned(eb));
		end
		op.sign = a_s1[31] ^ b_q[31];
		op.ma = na;
		op.mb = nb;
		op.e = xa - xb + 11'sd127;
		op.special = 1'b1;
		op.special_val = {op.sign, 31'd0};
		if (ea == 8'hFF && fa != '0) op.special_val = a_s1 | 32'h0040_0000;
		else if (eb == 8'hFF && fb != '0) op.special_val = b_q | 32'h0040_0000;
		else if (ea == 8'hFF)
			op.special_val = (eb == 8'hFF) ? QNAN_DEFAULT : {op.sign, 31'h7F80_0000};
		else if (eb == 8'hFF) op.special_val = {op.sign, 31'd0};
		else if (eb == 8'd0 && fb == '0)
			op.special_val = (ea == 8'd0 && fa == '0) ? QNAN_DEFAULT
				: {op.sign, 31'h7F80_0000};
		else if (ea == 8'd0 && fa == '0) op.special_val = {op.sign, 31'd0};
		else op.special = 1'b0;
	end

	cvd_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_READ), .op(op),
		.done(div_done), .result(div_res)
	);

	assign out_valid = out_valid_q;
	assign quotient = quo_q;
	assign channel = ch_out_q;
	assign last_out = last_out_q;

	`include "assert_macros.svh"
	`ASSERT_NEVER(a_done_idle, div_done && state_q != ST_DIV, "result outside divide")
	`ASSERT_CLK(a_wait_full, state_q == ST_WAIT |-> out_valid_q, "wait with empty output")
	`ASSERT_CLK(a_out_hold, out_valid_q && !out_ready |=> out_valid_q, "result dropped")
endmodule

// File: tb/channelwise_vector_over_map_divide_unit_tb.sv
module channelwise_vector_over_map_divide_unit_tb;
	import cvd_pkg::*;

	typedef struct packed {
		logic [31:0] quotient;
		logic [7:0]  channel;
		logic        last_out;
	} quotient_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd = CMD_LOAD;
	logic [7:0]  vec_index = '0;
	logic [31:0] value = '0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] quotient;
	logic [7:0]  channel;
	logic        last_out;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	channelwise_vector_over_map_divide_unit dut (.*);

	always #2 clk = ~clk;

	// predictor state
	logic [31:0]   vec_mirror [VecDepth];
	logic [7:0]    chan_pos = '0;
	logic [LenW-1:0] vec_len = 9'd1;
	quotient_rec_t pending_quotients [$];
	int            mismatches = 0;
	bit            quiet = 1'b0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	function automatic logic [31:0] f32_quotient(input logic [31:0] a, input logic [31:0] b);
		logic        sgn;
		logic [7:0]  ea, eb;
		logic [23:0] ma, mb;
		int          xa, xb, ex, sh;
		logic [63:0] num, q, lost;
		logic [31:0] mant, res;
		logic [2:0]  grs;
		sgn = a[31] ^ b[31];
		ea = a[30:23];
		eb = b[30:23];
		ma = {1'b0, a[22:0]};
		mb = {1'b0, b[22:0]};
		if (ea == 8'hFF && ma != 0) return a | 32'h0040_0000;
		if (eb == 8'hFF && mb != 0) return b | 32'h0040_0000;
		if (ea == 8'hFF) return (eb == 8'hFF) ? QNAN_DEFAULT : {sgn, 31'h7F80_0000};
		if (eb == 8'hFF) return {sgn, 31'h0};
		if (eb == 0 && mb == 0)
			return (ea == 0 && ma == 0) ? QNAN_DEFAULT : {sgn, 31'h7F80_0000};
		if (ea == 0 && ma == 0) return {sgn, 31'h0};
		// normalize denormal operands
		if (ea == 0) begin
			xa = 1;
			while (!ma[23]) begin
				ma = ma << 1;
				xa--;
			end
		end else begin
			xa = ea;
			ma[23] = 1'b1;
		end
		if (eb == 0) begin
			xb = 1;
			while (!mb[23]) begin
				mb = mb << 1;
				xb--;
			end
		end else begin
			xb = eb;
			mb[23] = 1'b1;
		end
		ex = xa - xb + 127;
		num = {40'h0, ma};
		if (ma < mb) begin
			num = num << 1;
			ex--;
		end
		q = (num << 26) / mb;
		if ((num << 26) % mb != 0) q[0] = 1'b1;
		if (ex >= 255) return {sgn, 31'h7F80_0000};
		if (ex <= 0) begin
			sh = 1 - ex;
			if (sh >= 32) q = (q != 0) ? 64'd1 : 64'd0;
			else begin
				lost = q & ((64'd1 << sh) - 1);
				q = (q >> sh) | ((lost != 0) ? 64'd1 : 64'd0);
			end
			ex = 1;
		end
		mant = q[34:3];
		grs = q[2:0];
		if (grs > 3'd4 || (grs == 3'd4 && mant[0])) mant++;
		res = (32'(ex - 1) << 23) + mant;
		if (res >= 32'h7F80_0000) res = 32'h7F80_0000;
		return {sgn, res[30:0]};
	endfunction

	// update mirror state for one accepted transaction; queue the quotient it causes
	task automatic predict_divide(input logic c, input logic [7:0] idx, input logic [31:0] v,
			input logic lst);
		quotient_rec_t r;
		logic [8:0] nxt;
		if (c == CMD_LOAD) begin
			vec_mirror[idx] = v;
			return;
		end
		r.quotient = f32_quotient(vec_mirror[chan_pos], v);
		r.channel = chan_pos;
		r.last_out = lst;
		pending_quotients.push_back(r);
		nxt = chan_pos + 9'd1;
		if (lst || nxt >= vec_len || nxt >= VecDepth) nxt = '0;
		chan_pos = nxt[7:0];
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input logic c, input logic [7:0] idx, input logic [31:0] v,
			input logic lst);
		in_valid = 1'b1;
		cmd = c;
		vec_index = idx;
		value = v;
		last = lst;
		forever begin
			@(posedge clk);
			if (in_ready) break;
		end
		predict_divide(c, idx, v, lst);
		@(negedge clk);
	endtask

	task automatic input_gap();
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		@(negedge clk);
		while (pending_quotients.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_length(input logic [31:0] len);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = REG_CHAN_COUNT;
		pwdata = len;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (prdata[8:0] !== len[8:0]) report_mismatch("channel count readback", prdata, len);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		vec_len = len[8:0];
	endtask

	function automatic logic [31:0] rand_f32();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: r[30:0] = '0;
			1: r[30:0] = 31'h7F80_0000;
			2: r[30:23] = 8'hFF;
			3: r[30:23] = 8'h00;
			4: r[30:23] = 8'(127 + $signed($urandom_range(0, 60)) - 30);
			5: r[30:23] = ($urandom_range(0, 1)) ? 8'h01 : 8'hFE;
			6: r[30:0] = {8'(127 + $urandom_range(0, 2) - 1), 23'h0};
			default: ;
		endcase
		return r;
	endfunction

	always @(negedge clk) begin : out_stall
		int hold;
		if (hold > 0) begin
			hold--;
			out_ready <= 1'b0;
		end else if (!quiet && arst_n && $urandom_range(0, 7) == 0) begin
			hold = $urandom_range(1, 6) - 1;
			out_ready <= 1'b0;
		end else out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_quotients.size() == 0)
				report_mismatch("unexpected quotient", quotient, 32'h0);
			else begin
				quotient_rec_t w;
				w = pending_quotients.pop_front();
				if (quotient !== w.quotient) report_mismatch("quotient", quotient, w.quotient);
				if (channel !== w.channel)
					report_mismatch("channel", {24'd0, channel}, {24'd0, w.channel});
				if (last_out !== w.last_out)
					report_mismatch("last_out", {31'd0, last_out}, {31'd0, w.last_out});
			end
		end
	end

	task automatic test_preload();
		for (int i = 0; i < VecDepth; i++) begin
			send_item(CMD_LOAD, 8'(i), rand_f32(), i[0]);
			input_gap();
		end
	endtask

	// each pair: load entry 0 with the dividend, then divide at length 1
	task automatic test_special_operands();
		logic [31:0] pairs [11][2] = '{
			'{32'h7FA1_2345, 32'h3F80_0000}, '{32'h3F80_0000, 32'hFF81_0001},
			'{32'h0000_0000, 32'h8000_0000}, '{32'h7F80_0000, 32'hFF80_0000},
			'{32'hBF80_0000, 32'h0000_0000}, '{32'hFF80_0000, 32'h4000_0000},
			'{32'h3F80_0000, 32'h7F80_0000}, '{32'h7F7F_FFFF, 32'h0000_0001},
			'{32'h0000_0001, 32'h4000_0000}, '{32'h0012_3456, 32'h8000_0333},
			'{32'h3F80_0000, 32'h4040_0000}};
		write_length(32'd1);
		foreach (pairs[i]) begin
			send_item(CMD_LOAD, 8'd0, pairs[i][0], 1'b1);
			send_item(CMD_DIV, 8'hFF, pairs[i][1], i[0]);
		end
		send_item(CMD_LOAD, 8'd255, 32'hFFFF_FFFF, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_phase(input logic [31:0] len, input int count);
		write_length(len);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(CMD_LOAD, 8'($urandom), rand_f32(), 1'($urandom));
			else
				send_item(CMD_DIV, 8'($urandom), rand_f32(), $urandom_range(0, 24) == 0);
			input_gap();
		end
		wait_idle();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_preload();
		wait_idle();
		test_special_operands();
		test_random_phase(32'd256, 400);
		test_random_phase(32'd3, 150);
		test_random_phase(32'd0, 60);
		test_random_phase(32'h1FF, 300);
		test_random_phase(32'($urandom_range(2, 255)), 250);
		test_random_phase(32'($urandom_range(1, 16)), 200);
		quiet = 1'b1;
		test_random_phase(32'd256, 200);
		if (mismatches == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	initial begin
		#3000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
